FILE: hw/rtl/comb_allpass_stereo_reverb_defines.svh
// Assertion macros for the reverb RTL.
`ifndef COMB_ALLPASS_STEREO_REVERB_DEFINES_SVH
`define COMB_ALLPASS_STEREO_REVERB_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define CASR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define CASR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CASR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CASR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/casr_pkg.sv
package casr_pkg;

  localparam int NUM_COMBS            = 8;
  localparam int NUM_ALLPASS          = 4;
  localparam int MAX_COMB_LEN_DEF     = 4096;
  localparam int MAX_ALLPASS_LEN_DEF  = 1024;
  localparam int MAX_PREDELAY_LEN_DEF = 8192;
  localparam int SAMPLE_BITS          = 16;
  localparam int WORD_BITS            = 24;
  localparam int MIN_LINE_LEN         = 10;
  localparam int AP_GAIN              = 22938;
  localparam int FB_RESET             = -31785;

  // Channel gain is Q2.12 and the comb sum is divided by the comb count.
  localparam int OUT_SHIFT = 12 + $clog2(NUM_COMBS);

  localparam int CLINES  = 2 * NUM_COMBS;
  localparam int ALINES  = 2 * NUM_ALLPASS;
  localparam int CLINE_W = $clog2(CLINES);
  localparam int ALINE_W = $clog2(ALINES);
  localparam int JW      = ($clog2(NUM_COMBS) > $clog2(NUM_ALLPASS)) ?
                           $clog2(NUM_COMBS) : $clog2(NUM_ALLPASS);
  localparam int SUMW    = WORD_BITS + $clog2(NUM_COMBS) + 1;

  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_ADDR_W-1:0] REG_DAMP_COEF    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PREDELAY_LEN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PREDELAY_FB  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_GAIN    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_GAIN   = 3'd4;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_LOAD_COMB = 2'd1,
    CMD_LOAD_AP   = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_CLR_ALL, ST_CLR_PD, ST_IDLE,
    ST_PD_RD, ST_PD_MUL, ST_PD_WR,
    ST_C_RD, ST_C_M1, ST_C_M2, ST_C_M3, ST_C_F, ST_C_WR,
    ST_SUM_SAT,
    ST_A_RD, ST_A_M1, ST_A_S, ST_A_M2, ST_A_SUM,
    ST_O_MUL, ST_O_RES, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR_ALL, OP_CLR_PD, OP_LATCH, OP_LOAD_COMB, OP_LOAD_AP,
    OP_PD_RD, OP_PD_MUL, OP_PD_WR,
    OP_C_RD, OP_C_M1, OP_C_M2, OP_C_M3, OP_C_F, OP_C_WR,
    OP_SUM_SAT,
    OP_A_RD, OP_A_M1, OP_A_S, OP_A_M2, OP_A_SUM,
    OP_O_MUL, OP_O_RES, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t           op;
    logic          ch;
    logic [JW-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic pd_active;
    logic pd_change;
    logic clr_last;
  } dp_stat_t;

  localparam logic signed [PROD_W-1:0] WORD_MAX_P = PROD_W'((1 << (WORD_BITS - 1)) - 1);
  localparam logic signed [PROD_W-1:0] WORD_MIN_P = PROD_W'(-(1 << (WORD_BITS - 1)));
  localparam logic signed [PROD_W-1:0] SMP_MAX_P  = PROD_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SMP_MIN_P  = PROD_W'(-(1 << (SAMPLE_BITS - 1)));

  // Divide by 2**sh, rounding half up.
  function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] p,
                                                        input int sh);
    logic signed [PROD_W-1:0] half;
    half = PROD_W'(1) <<< (sh - 1);
    return (p + half) >>> sh;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = (v > WORD_MAX_P) ? WORD_MAX_P : ((v < WORD_MIN_P) ? WORD_MIN_P : v);
    return t[WORD_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = (v > SMP_MAX_P) ? SMP_MAX_P : ((v < SMP_MIN_P) ? SMP_MIN_P : v);
    return t[SAMPLE_BITS-1:0];
  endfunction

endpackage

FILE: hw/rtl/comb_allpass_stereo_reverb.sv
// Stereo comb/allpass reverb.
// Input stream: in_tuser carries the command (sample, load comb, load allpass,
// clear stores); in_tdata carries the sample pair and the line load fields.
// A sample command produces one output transfer with the left and right reverb
// outputs; the other commands produce none.
// A sample runs the pre-delay (read, multiply, write; only the read when
// bypassed), then per channel each comb (read, three multiply steps, filter,
// write), the comb sum saturation, each allpass (read, multiply, sum, multiply,
// sum) and the output gain, then loads the output register; the next input is
// taken in the cycle after that. All steps share one 26x18 multiplier and one
// read and one write port per delay memory. Loads do not leave the idle state.
// A clear command sweeps all delay memories, one word per cycle; a predelay
// length write that changes the effective length sweeps the pre-delay memory.
// No input is taken during a sweep. After reset the same full sweep runs before
// in_tready rises. The result waits in an output register: the next item is
// taken while it is stalled, and a new result waits until the previous one has
// been taken. Configuration writes go through cfg_we/cfg_addr/cfg_wdata while
// idle; the user must keep to this, as the block does not enforce it.
`include "comb_allpass_stereo_reverb_defines.svh"

module comb_allpass_stereo_reverb
  import casr_pkg::*;
#(
  parameter int MAX_COMB_LEN     = MAX_COMB_LEN_DEF,
  parameter int MAX_ALLPASS_LEN  = MAX_ALLPASS_LEN_DEF,
  parameter int MAX_PREDELAY_LEN = MAX_PREDELAY_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // left_in[15:0], right_in[31:16], line_index[35:32], line_length[48:36],
  // comb_gain[64:49], zero fill[71:65]
  input  logic [71:0]           in_tdata,
  // cmd[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // left_out[15:0], right_out[31:16]
  output logic [31:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic signed [SAMPLE_BITS-1:0] left_out, right_out;

  casr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (cmd_t'(in_tuser)),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  casr_dp #(
    .MAX_COMB_LEN     (MAX_COMB_LEN),
    .MAX_ALLPASS_LEN  (MAX_ALLPASS_LEN),
    .MAX_PREDELAY_LEN (MAX_PREDELAY_LEN)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .left_in     (in_tdata[15:0]),
    .right_in    (in_tdata[31:16]),
    .line_index  (in_tdata[35:32]),
    .line_length (in_tdata[48:36]),
    .comb_gain   (in_tdata[64:49]),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .left_out    (left_out),
    .right_out   (right_out)
  );

  assign out_tdata = {right_out, left_out};

  // A sample transfer occupies the block; no second item is taken right after it.
  `CASR_ASSERT_NXT(a_sample_busy, clk, rst_n, in_tvalid && in_tready && in_tuser == CMD_SAMPLE, !in_tready, "input taken right after a sample transfer")
  // A clear command starts a sweep that blocks input.
  `CASR_ASSERT_NXT(a_clear_busy, clk, rst_n, in_tvalid && in_tready && in_tuser == CMD_CLEAR, !in_tready, "input taken during clear sweep")
  // A changed pre-delay length starts a sweep that blocks input.
  `CASR_ASSERT_NXT(a_pd_sweep, clk, rst_n, dp_stat.pd_change, !in_tready, "input taken during pre-delay sweep")
  // A result is loaded only into a free output register.
  `CASR_ASSERT_IMP(a_emit_free, clk, rst_n, dp_cmd.op == OP_EMIT, !out_tvalid || out_tready, "result overwrote a pending output")

endmodule

FILE: hw/rtl/casr_ctrl.sv
module casr_ctrl
  import casr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  cmd_t     in_cmd,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output dp_cmd_t  dp_cmd,
  input  dp_stat_t dp_stat
);

  localparam logic [JW-1:0] LAST_COMB = JW'(NUM_COMBS - 1);
  localparam logic [JW-1:0] LAST_AP   = JW'(NUM_ALLPASS - 1);

  state_t        state_r, state_nxt;
  logic          ch_r, ch_nxt;
  logic [JW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR_ALL;
      ch_r        <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_CLR_ALL, ST_CLR_PD: begin
        if (dp_stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        ch_nxt  = 1'b0;
        idx_nxt = '0;
        if (dp_stat.pd_change) begin
          state_nxt = ST_CLR_PD;
        end else if (in_tvalid) begin
          case (in_cmd)
            CMD_SAMPLE: state_nxt = ST_PD_RD;
            CMD_CLEAR:  state_nxt = ST_CLR_ALL;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PD_RD:   state_nxt = dp_stat.pd_active ? ST_PD_MUL : ST_C_RD;
      ST_PD_MUL:  state_nxt = ST_PD_WR;
      ST_PD_WR:   state_nxt = ST_C_RD;
      ST_C_RD:    state_nxt = ST_C_M1;
      ST_C_M1:    state_nxt = ST_C_M2;
      ST_C_M2:    state_nxt = ST_C_M3;
      ST_C_M3:    state_nxt = ST_C_F;
      ST_C_F:     state_nxt = ST_C_WR;
      ST_C_WR: begin
        if (idx_r == LAST_COMB) begin
          idx_nxt   = '0;
          state_nxt = ST_SUM_SAT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_C_RD;
        end
      end
      ST_SUM_SAT: state_nxt = ST_A_RD;
      ST_A_RD:    state_nxt = ST_A_M1;
      ST_A_M1:    state_nxt = ST_A_S;
      ST_A_S:     state_nxt = ST_A_M2;
      ST_A_M2:    state_nxt = ST_A_SUM;
      ST_A_SUM: begin
        if (idx_r == LAST_AP) begin
          idx_nxt   = '0;
          state_nxt = ST_O_MUL;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_A_RD;
        end
      end
      ST_O_MUL:   state_nxt = ST_O_RES;
      ST_O_RES: begin
        if (ch_r) begin
          state_nxt = ST_EMIT;
        end else begin
          ch_nxt    = 1'b1;
          state_nxt = ST_C_RD;
        end
      end
      ST_EMIT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLR_ALL;
    endcase
  end

  // Outputs.
  always_comb begin
    dp_cmd.op  = OP_NONE;
    dp_cmd.ch  = ch_r;
    dp_cmd.idx = idx_r;
    in_tready  = 1'b0;
    case (state_r)
      ST_CLR_ALL: dp_cmd.op = OP_CLR_ALL;
      ST_CLR_PD:  dp_cmd.op = OP_CLR_PD;
      ST_IDLE: begin
        in_tready = !dp_stat.pd_change;
        if (in_tvalid && !dp_stat.pd_change) begin
          case (in_cmd)
            CMD_SAMPLE:    dp_cmd.op = OP_LATCH;
            CMD_LOAD_COMB: dp_cmd.op = OP_LOAD_COMB;
            CMD_LOAD_AP:   dp_cmd.op = OP_LOAD_AP;
            default:       dp_cmd.op = OP_NONE;
          endcase
        end
      end
      ST_PD_RD:   dp_cmd.op = OP_PD_RD;
      ST_PD_MUL:  dp_cmd.op = OP_PD_MUL;
      ST_PD_WR:   dp_cmd.op = OP_PD_WR;
      ST_C_RD:    dp_cmd.op = OP_C_RD;
      ST_C_M1:    dp_cmd.op = OP_C_M1;
      ST_C_M2:    dp_cmd.op = OP_C_M2;
      ST_C_M3:    dp_cmd.op = OP_C_M3;
      ST_C_F:     dp_cmd.op = OP_C_F;
      ST_C_WR:    dp_cmd.op = OP_C_WR;
      ST_SUM_SAT: dp_cmd.op = OP_SUM_SAT;
      ST_A_RD:    dp_cmd.op = OP_A_RD;
      ST_A_M1:    dp_cmd.op = OP_A_M1;
      ST_A_S:     dp_cmd.op = OP_A_S;
      ST_A_M2:    dp_cmd.op = OP_A_M2;
      ST_A_SUM:   dp_cmd.op = OP_A_SUM;
      ST_O_MUL:   dp_cmd.op = OP_O_MUL;
      ST_O_RES:   dp_cmd.op = OP_O_RES;
      ST_EMIT:    dp_cmd.op = slot_free ? OP_EMIT : OP_NONE;
      default:    dp_cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    if (state_r == ST_EMIT && slot_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: hw/rtl/casr_dp.sv
module casr_dp
  import casr_pkg::*;
#(
  parameter int MAX_COMB_LEN     = MAX_COMB_LEN_DEF,
  parameter int MAX_ALLPASS_LEN  = MAX_ALLPASS_LEN_DEF,
  parameter int MAX_PREDELAY_LEN = MAX_PREDELAY_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic [3:0]                    line_index,
  input  logic [12:0]                   line_length,
  input  logic signed [15:0]            comb_gain,
  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out
);

  localparam int CPW = $clog2(MAX_COMB_LEN);
  localparam int CLW = $clog2(MAX_COMB_LEN + 1);
  localparam int APW = $clog2(MAX_ALLPASS_LEN);
  localparam int ALW = $clog2(MAX_ALLPASS_LEN + 1);
  localparam int PPW = $clog2(MAX_PREDELAY_LEN);
  localparam int PLW = $clog2(MAX_PREDELAY_LEN + 1);
  localparam int CAW = CLINE_W + CPW;
  localparam int AAW = ALINE_W + APW;
  localparam int CDEPTH = 1 << CAW;
  localparam int ADEPTH = 1 << AAW;
  localparam int PDEPTH = 1 << PPW;
  localparam int CLR_W  = (CAW > AAW) ? ((CAW > PPW) ? CAW : PPW) : ((AAW > PPW) ? AAW : PPW);
  localparam logic [CLR_W-1:0] CLR_ALL_LAST = '1;
  localparam logic [CLR_W-1:0] CLR_PD_LAST  = CLR_W'(PDEPTH - 1);
  localparam logic signed [MUL_B_W-1:0] AP_GAIN_B = MUL_B_W'(AP_GAIN);

  function automatic logic [PLW-1:0] eff_len(input logic [13:0] v);
    if (32'(v) > MAX_PREDELAY_LEN) return PLW'(MAX_PREDELAY_LEN);
    return PLW'(v);
  endfunction

  function automatic logic [31:0] clamp_len(input logic [12:0] v, input int max_len);
    if (32'(v) < MIN_LINE_LEN) return 32'(MIN_LINE_LEN);
    if (32'(v) > max_len) return 32'(max_len);
    return 32'(v);
  endfunction

  // Configuration registers.
  logic [14:0] damp_coef_r;
  logic [13:0] pd_len_r;
  logic [6:0]  pd_fb_r;
  logic [13:0] lgain_r, rgain_r;

  // Per-line state.
  logic [CPW-1:0]              c_pos_r [CLINES];
  logic [CLW-1:0]              c_len_r [CLINES];
  logic signed [15:0]          c_fb_r  [CLINES];
  logic signed [WORD_BITS-1:0] damp_r  [CLINES];
  logic [APW-1:0]              a_pos_r [ALINES];
  logic [ALW-1:0]              a_len_r [ALINES];
  logic [PPW-1:0]              pd_pos_r;
  logic [CLR_W-1:0]            clr_cnt_r;

  // Working registers.
  logic signed [SAMPLE_BITS-1:0] il_r, ir_r;
  logic signed [WORD_BITS-1:0]   x_r, f_r, t_r, s_r;
  logic signed [SUMW-1:0]        sum_r;
  logic signed [PROD_W-1:0]      prod_r, acc_r;
  logic [CPW-1:0]                cp_r;
  logic [APW-1:0]                ap_r;
  logic [PPW-1:0]                pp_r;
  logic signed [SAMPLE_BITS-1:0] lres_r, rres_r;

  // Memories.
  logic signed [WORD_BITS-1:0] comb_mem [CDEPTH];
  logic signed [WORD_BITS-1:0] ap_mem   [ADEPTH];
  logic signed [WORD_BITS-1:0] pd_mem   [PDEPTH];
  logic signed [WORD_BITS-1:0] c_q, a_q, pd_q;

  logic [CLINE_W-1:0]  n;
  logic [ALINE_W-1:0]  m;
  logic [CPW-1:0]      cp;
  logic [APW-1:0]      ap;
  logic [PPW-1:0]      pp;
  logic [PLW-1:0]      pd_eff, pd_new_eff;
  logic [CPW-1:0]      cp_next;
  logic [APW-1:0]      ap_next;
  logic [PPW-1:0]      pp_next;
  logic                clr_op, clr_last;
  logic                c_we, a_we, pd_we;
  logic [CAW-1:0]      c_waddr;
  logic [AAW-1:0]      a_waddr;
  logic [PPW-1:0]      pd_waddr;
  logic signed [WORD_BITS-1:0] c_wdata, a_wdata, pd_wdata;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [SAMPLE_BITS:0] mono_sum;
  logic                        lc_ok, la_ok;
  logic [CLINE_W-1:0]          lc_idx;
  logic [ALINE_W-1:0]          la_idx;

  assign n  = CLINE_W'(cmd.ch ? NUM_COMBS : 0) + CLINE_W'(cmd.idx);
  assign m  = ALINE_W'(cmd.ch ? NUM_ALLPASS : 0) + ALINE_W'(cmd.idx);
  assign cp = (32'(c_pos_r[n]) >= 32'(c_len_r[n])) ? '0 : c_pos_r[n];
  assign ap = (32'(a_pos_r[m]) >= 32'(a_len_r[m])) ? '0 : a_pos_r[m];
  assign pd_eff = eff_len(pd_len_r);
  assign pp = (32'(pd_pos_r) >= 32'(pd_eff)) ? '0 : pd_pos_r;
  assign cp_next = (32'(cp_r) + 1 >= 32'(c_len_r[n])) ? '0 : cp_r + 1'b1;
  assign ap_next = (32'(ap_r) + 1 >= 32'(a_len_r[m])) ? '0 : ap_r + 1'b1;
  assign pp_next = (32'(pp_r) + 1 >= 32'(pd_eff)) ? '0 : pp_r + 1'b1;

  assign pd_new_eff = eff_len(cfg_wdata[13:0]);
  assign stat.pd_change = cfg_we && (cfg_addr == REG_PREDELAY_LEN) && (pd_new_eff != pd_eff);
  assign stat.pd_active = (32'(pd_eff) > 1);

  assign clr_op   = (cmd.op == OP_CLR_ALL) || (cmd.op == OP_CLR_PD);
  assign clr_last = (cmd.op == OP_CLR_PD) ? (clr_cnt_r == CLR_PD_LAST)
                                          : (clr_cnt_r == CLR_ALL_LAST);
  assign stat.clr_last = clr_last;

  assign mono_sum = (SAMPLE_BITS + 1)'(il_r) + (SAMPLE_BITS + 1)'(ir_r);

  assign lc_ok  = (32'(line_index) < CLINES);
  assign la_ok  = (32'(line_index) < ALINES);
  assign lc_idx = line_index[CLINE_W-1:0];
  assign la_idx = line_index[ALINE_W-1:0];

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_PD_MUL: begin
        mul_a = MUL_A_W'(pd_q);
        mul_b = MUL_B_W'({1'b0, pd_fb_r});
      end
      OP_C_M1: begin
        mul_a = MUL_A_W'(c_q);
        mul_b = MUL_B_W'(c_fb_r[n]);
      end
      OP_C_M2: begin
        mul_a = MUL_A_W'(rnd_shr(prod_r, 15));
        mul_b = MUL_B_W'(17'd32768 - {2'b00, damp_coef_r});
      end
      OP_C_M3: begin
        mul_a = MUL_A_W'(damp_r[n]);
        mul_b = MUL_B_W'({1'b0, damp_coef_r});
      end
      OP_A_M1: begin
        mul_a = MUL_A_W'(a_q);
        mul_b = AP_GAIN_B;
      end
      OP_A_M2: begin
        mul_a = MUL_A_W'(s_r);
        mul_b = AP_GAIN_B;
      end
      OP_O_MUL: begin
        mul_a = MUL_A_W'(sum_r);
        mul_b = cmd.ch ? MUL_B_W'({1'b0, rgain_r}) : MUL_B_W'({1'b0, lgain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Memory write ports.
  always_comb begin
    c_we     = 1'b0;
    c_waddr  = {n, cp_r};
    c_wdata  = sat_word(PROD_W'(x_r) + PROD_W'(f_r));
    a_we     = 1'b0;
    a_waddr  = {m, ap_r};
    a_wdata  = s_r;
    pd_we    = 1'b0;
    pd_waddr = pp_r;
    pd_wdata = sat_word(PROD_W'(x_r) + rnd_shr(prod_r, 7));
    if (clr_op) begin
      c_waddr  = CAW'(clr_cnt_r);
      a_waddr  = AAW'(clr_cnt_r);
      pd_waddr = PPW'(clr_cnt_r);
      c_wdata  = '0;
      a_wdata  = '0;
      pd_wdata = '0;
      c_we     = (cmd.op == OP_CLR_ALL) && (32'(clr_cnt_r) < CDEPTH);
      a_we     = (cmd.op == OP_CLR_ALL) && (32'(clr_cnt_r) < ADEPTH);
      pd_we    = (32'(clr_cnt_r) < PDEPTH);
    end else begin
      c_we  = (cmd.op == OP_C_WR);
      a_we  = (cmd.op == OP_A_M2);
      pd_we = (cmd.op == OP_PD_WR);
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) comb_mem[c_waddr] <= c_wdata;
    if (cmd.op == OP_C_RD) c_q <= comb_mem[{n, cp}];
  end

  always_ff @(posedge clk) begin
    if (a_we) ap_mem[a_waddr] <= a_wdata;
    if (cmd.op == OP_A_RD) a_q <= ap_mem[{m, ap}];
  end

  always_ff @(posedge clk) begin
    if (pd_we) pd_mem[pd_waddr] <= pd_wdata;
    if (cmd.op == OP_PD_RD) pd_q <= pd_mem[pp];
  end

  // Control and per-line state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_coef_r <= '0;
      pd_len_r    <= '0;
      pd_fb_r     <= '0;
      lgain_r     <= 14'd2048;
      rgain_r     <= 14'd2048;
      pd_pos_r    <= '0;
      clr_cnt_r   <= '0;
      for (int i = 0; i < CLINES; i++) begin
        c_pos_r[i] <= '0;
        c_len_r[i] <= CLW'(MIN_LINE_LEN);
        c_fb_r[i]  <= 16'(FB_RESET);
        damp_r[i]  <= '0;
      end
      for (int i = 0; i < ALINES; i++) begin
        a_pos_r[i] <= '0;
        a_len_r[i] <= ALW'(MIN_LINE_LEN);
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_DAMP_COEF:    damp_coef_r <= cfg_wdata[14:0];
          REG_PREDELAY_LEN: pd_len_r    <= cfg_wdata[13:0];
          REG_PREDELAY_FB:  pd_fb_r     <= cfg_wdata[6:0];
          REG_LEFT_GAIN:    lgain_r     <= cfg_wdata[13:0];
          REG_RIGHT_GAIN:   rgain_r     <= cfg_wdata[13:0];
          default:          ;
        endcase
      end
      if (stat.pd_change) pd_pos_r <= '0;
      if (clr_op) clr_cnt_r <= clr_last ? '0 : clr_cnt_r + 1'b1;
      case (cmd.op)
        OP_CLR_ALL: begin
          for (int i = 0; i < CLINES; i++) damp_r[i] <= '0;
        end
        OP_LOAD_COMB: begin
          if (lc_ok) begin
            c_len_r[lc_idx] <= CLW'(clamp_len(line_length, MAX_COMB_LEN));
            c_pos_r[lc_idx] <= '0;
            damp_r[lc_idx]  <= '0;
            c_fb_r[lc_idx]  <= comb_gain;
          end
        end
        OP_LOAD_AP: begin
          if (la_ok) begin
            a_len_r[la_idx] <= ALW'(clamp_len(line_length, MAX_ALLPASS_LEN));
            a_pos_r[la_idx] <= '0;
          end
        end
        OP_PD_WR: pd_pos_r <= pp_next;
        OP_C_WR: begin
          damp_r[n]  <= f_r;
          c_pos_r[n] <= cp_next;
        end
        OP_A_SUM: a_pos_r[m] <= ap_next;
        default: ;
      endcase
    end
  end

  // Arithmetic pipeline registers.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a * mul_b);
    case (cmd.op)
      OP_LATCH: begin
        il_r <= left_in;
        ir_r <= right_in;
      end
      OP_PD_RD: begin
        x_r  <= WORD_BITS'(mono_sum >>> 1);
        pp_r <= pp;
      end
      OP_PD_WR: x_r <= pd_q;
      OP_C_RD:  cp_r <= cp;
      OP_C_M3:  acc_r <= prod_r;
      OP_C_F:   f_r <= sat_word(rnd_shr(acc_r + prod_r, 15));
      OP_C_WR: begin
        if (cmd.idx == '0) begin
          sum_r <= SUMW'(f_r);
        end else begin
          sum_r <= sum_r + SUMW'(f_r);
        end
      end
      OP_SUM_SAT: sum_r <= SUMW'(sat_word(PROD_W'(sum_r)));
      OP_A_RD:  ap_r <= ap;
      OP_A_M1:  t_r <= a_q;
      OP_A_S:   s_r <= sat_word(rnd_shr(prod_r, 15) + PROD_W'(sum_r));
      OP_A_SUM: sum_r <= SUMW'(sat_word(PROD_W'(t_r) - rnd_shr(prod_r, 15)));
      OP_O_RES: begin
        if (cmd.ch) begin
          rres_r <= sat_sample(rnd_shr(prod_r, OUT_SHIFT));
        end else begin
          lres_r <= sat_sample(rnd_shr(prod_r, OUT_SHIFT));
        end
      end
      OP_EMIT: begin
        left_out  <= lres_r;
        right_out <= rres_r;
      end
      default: ;
    endcase
  end

endmodule
